// File: rtl/skl_pkg.sv
// Package for the sorted key list: item types, opcode and status codes,
// and the command and flag structs that join the controller and datapath.
// No dependencies.
package skl_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key_value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] key_echo;
        logic [4:0]         entry_count;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_prev;
        logic    wr_en;
        logic    wr_prev;
        logic    wr_key;
        logic    idx_inc;
        logic    idx_dec;
        logic    count_inc;
        logic    count_dec;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic key_less;
        logic key_equal;
        logic out_busy;
    } t_dp_flags;

endpackage

// File: rtl/skl_ctrl.sv
// Controller of the sorted key list: sequences the scan, shift and result
// steps of one item. Depends on skl_pkg for the command and flag structs.
module skl_ctrl
    import skl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_flags i_flags,
    output t_dp_cmd   o_cmd,
    output logic      o_in_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INS_CHK,
        S_INS_EVAL,
        S_FWD_CHK,
        S_FWD_EVAL,
        S_DEL_CHK,
        S_DEL_EVAL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_flags.is_insert) begin
                    if (i_flags.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_INS_CHK;
                    end
                end else begin
                    n_state = S_FWD_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_flags.idx_zero) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_key     = 1'b1;
                    o_cmd.count_inc  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_EVAL;
                end
            end
            S_INS_EVAL: begin
                if (!i_flags.key_less) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_INS_CHK;
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_key     = 1'b1;
                    o_cmd.count_inc  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_FWD_CHK: begin
                if (i_flags.idx_at_count) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_MISS;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_FWD_EVAL;
                end
            end
            S_FWD_EVAL: begin
                if (i_flags.key_less) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FWD_CHK;
                end else if (i_flags.key_equal) begin
                    if (i_flags.is_delete) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DEL_CHK;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_OK;
                        n_state          = S_DONE;
                    end
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_MISS;
                    n_state          = S_DONE;
                end
            end
            S_DEL_CHK: begin
                if (i_flags.idx_at_count) begin
                    o_cmd.count_dec  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DEL_EVAL;
                end
            end
            S_DEL_EVAL: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_prev = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_DONE: begin
                if (!i_flags.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/skl_dp.sv
// Datapath of the sorted key list: key memory, scan index, entry count,
// comparator and output register. Depends on skl_pkg; driven by skl_ctrl.
module skl_dp
    import skl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_flags o_flags,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [KEY_WIDTH-1:0] r_key;
    logic [1:0]           r_op;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_count;
    t_status              r_status;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic [KEY_WIDTH+31:0] key_ext;
    logic [KEY_WIDTH+31:0] echo_ext;
    logic [CW+4:0]         count_ext;
    logic [CW-1:0]         idx_m1;
    logic [CW-1:0]         rd_idx;
    logic [CW-1:0]         wr_idx;
    logic [KEY_WIDTH-1:0]  wr_data;

    assign key_ext   = {{KEY_WIDTH{1'b0}}, i_in_item.key_value};
    assign echo_ext  = {32'b0, r_key};
    assign count_ext = {5'b0, r_count};
    assign idx_m1    = r_idx - 1'b1;
    assign rd_idx    = i_cmd.rd_prev ? idx_m1 : r_idx;
    assign wr_idx    = i_cmd.wr_prev ? idx_m1 : r_idx;
    assign wr_data   = i_cmd.wr_key ? r_key : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= key_ext[KEY_WIDTH-1:0];
            r_op  <= i_in_item.opcode;
            r_idx <= (i_in_item.opcode == OP_INSERT) ? r_count : '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_item.status      <= r_status;
            r_out_item.key_echo    <= echo_ext[31:0];
            r_out_item.entry_count <= count_ext[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.count_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_flags.is_insert    = (r_op == OP_INSERT);
    assign o_flags.is_delete    = (r_op == OP_DELETE);
    assign o_flags.full         = (r_count == CAP_C);
    assign o_flags.idx_zero     = (r_idx == '0);
    assign o_flags.idx_at_count = (r_idx == r_count);
    assign o_flags.key_less     = ($signed(r_rd_data) < $signed(r_key));
    assign o_flags.key_equal    = (r_rd_data == r_key);
    assign o_flags.out_busy     = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (wr_idx < CAP_C))
        else $error("memory write beyond capacity");
    a_no_inc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_inc |-> (r_count < CAP_C))
        else $error("insert stored into a full table");
    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_dec |-> (r_count != '0))
        else $error("delete from an empty table");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule

// File: rtl/sorted_key_list_core.sv
// Top level of the sorted key list: a bounded ascending multiset of keys.
// Depends on skl_pkg, skl_ctrl and skl_dp.
//
// Usage:
// The input channel takes one item (opcode, key_value) when i_in_valid is
// high and o_in_stall is low. Opcode insert, delete or search; any other
// code acts as a search. Each item gives exactly one result item on the
// output channel, taken when o_out_valid is high and i_out_stall is low.
// Keys are held in a single-port memory in ascending order, so an item
// walks the stored keys with one memory read per key it examines. A search
// or a delete scans from the front and stops at the first key not less
// than its own, or at the end; a delete that finds its key then moves
// each later key down one place. An insert scans from the back, moving
// each key not less than the new key up one place, and stores the new
// key in the gap. A full-table insert gives its result without a scan.
// The result is loaded in the cycle before the next item can be
// accepted. Reset empties the table; no clearing pass is needed. If the
// receiver stalls, the result stays in the output register and the block
// holds the following result until that register is free.
module sorted_key_list_core
    import skl_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    t_dp_cmd   cmd;
    t_dp_flags flags;

    skl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    skl_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
